// ----- rtl/tfpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfpc_pkg
// Types and constants shared by the tank fill pump controller modules.
// ----------------------------------------------------------------------------
package tfpc_pkg;

  localparam int TimeW = 32;
  localparam int CfgIdxW = 3;

  typedef logic [TimeW-1:0] time_ms_t;

  // Command codes
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_RESUME = 2'd2;

  // Reported controller state codes
  localparam logic [1:0] CTRL_IDLE  = 2'd0;
  localparam logic [1:0] CTRL_FILL  = 2'd1;
  localparam logic [1:0] CTRL_COOL  = 2'd2;
  localparam logic [1:0] CTRL_FAULT = 2'd3;

  // Tank level codes
  localparam logic [1:0] LVL_UNKNOWN = 2'd0;
  localparam logic [1:0] LVL_EMPTY   = 2'd1;
  localparam logic [1:0] LVL_PARTIAL = 2'd2;
  localparam logic [1:0] LVL_FULL    = 2'd3;

  // Fault codes
  localparam logic [1:0] FLT_SENSORS   = 2'd0;
  localparam logic [1:0] FLT_FLOW_OFF  = 2'd1;
  localparam logic [1:0] FLT_NO_FLOW   = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_UPDATE_DELAY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NO_FLOW      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_FILL     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ALLOW_DELAY  = 3'd4;

  // Register reset values
  localparam time_ms_t RST_UPDATE_DELAY = 32'd1000;
  localparam time_ms_t RST_NO_FLOW      = 32'd60000;
  localparam time_ms_t RST_MAX_FILL     = 32'd1800000;
  localparam time_ms_t RST_COOLDOWN     = 32'd600000;
  localparam time_ms_t RST_ALLOW_DELAY  = 32'd60000;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FILL  = 4'b0010,
    ST_COOL  = 4'b0100,
    ST_FAULT = 4'b1000
  } mode_t;

  typedef struct packed {
    time_ms_t update_delay_ms;
    time_ms_t no_flow_timeout_ms;
    time_ms_t max_fill_time_ms;
    time_ms_t cooldown_ms;
    time_ms_t allow_watering_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    time_ms_t   now_ms;
    logic       high_level;
    logic       low_level;
    logic       flow_detected;
    logic       watering_blocked;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] ctrl_state;
    logic [1:0] tank_level;
    logic       pump_on;
    logic       fault_raised;
    logic [1:0] fault_code;
    logic       block_watering;
    logic       allow_watering;
  } result_t;

endpackage

// ----- rtl/tfpc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfpc_cfg
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tfpc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tfpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  tfpc_pkg::time_ms_t              cfg_data,
  output tfpc_pkg::cfg_t                  cfg
);
  import tfpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_delay_ms         <= RST_UPDATE_DELAY;
      cfg.no_flow_timeout_ms      <= RST_NO_FLOW;
      cfg.max_fill_time_ms        <= RST_MAX_FILL;
      cfg.cooldown_ms             <= RST_COOLDOWN;
      cfg.allow_watering_delay_ms <= RST_ALLOW_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPDATE_DELAY: cfg.update_delay_ms         <= cfg_data;
        REG_NO_FLOW:      cfg.no_flow_timeout_ms      <= cfg_data;
        REG_MAX_FILL:     cfg.max_fill_time_ms        <= cfg_data;
        REG_COOLDOWN:     cfg.cooldown_ms             <= cfg_data;
        REG_ALLOW_DELAY:  cfg.allow_watering_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/tfpc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfpc_core
// Controller state and the combinational step that processes one item.
// ----------------------------------------------------------------------------
module tfpc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tfpc_pkg::item_t  item,
  input  tfpc_pkg::cfg_t   cfg,
  output tfpc_pkg::result_t res
);
  import tfpc_pkg::*;

  mode_t      mode, mode_next;
  logic [1:0] level, level_next;
  logic       first_pending, first_pending_next;
  time_ms_t   last_update_time, last_update_time_next;
  time_ms_t   fill_start_time, fill_start_time_next;
  time_ms_t   cooldown_start_time, cooldown_start_time_next;
  time_ms_t   water_since, water_since_next;

  logic       due;
  logic [1:0] lvl_new;
  time_ms_t   fill_elapsed;
  logic       flt;
  logic [1:0] flt_code;
  logic       blk, alw, acc;
  logic [1:0] state_code;

  always_comb begin
    mode_next                = mode;
    level_next               = level;
    first_pending_next       = first_pending;
    last_update_time_next    = last_update_time;
    fill_start_time_next     = fill_start_time;
    cooldown_start_time_next = cooldown_start_time;
    water_since_next         = water_since;
    acc      = 1'b0;
    flt      = 1'b0;
    flt_code = FLT_SENSORS;
    blk      = 1'b0;
    alw      = 1'b0;

    due = first_pending ||
          ((item.now_ms - last_update_time) >= cfg.update_delay_ms);
    lvl_new = item.high_level ? LVL_FULL : (item.low_level ? LVL_PARTIAL : LVL_EMPTY);
    fill_elapsed = item.now_ms - fill_start_time;

    case (item.command)
      CMD_UPDATE: begin
        if (due) begin
          first_pending_next    = 1'b0;
          last_update_time_next = item.now_ms;
          acc                   = 1'b1;
          if (item.high_level && !item.low_level) begin
            level_next = LVL_UNKNOWN;
            flt        = 1'b1;
            flt_code   = FLT_SENSORS;
            mode_next  = ST_FAULT;
          end else begin
            level_next = lvl_new;
            unique case (mode)
              ST_IDLE: begin
                if (item.flow_detected) begin
                  flt       = 1'b1;
                  flt_code  = FLT_FLOW_OFF;
                  mode_next = ST_FAULT;
                end else if (lvl_new == LVL_EMPTY) begin
                  mode_next            = ST_FILL;
                  fill_start_time_next = item.now_ms;
                end
              end
              ST_FILL: begin
                if (!item.flow_detected && fill_elapsed >= cfg.no_flow_timeout_ms) begin
                  flt       = 1'b1;
                  flt_code  = FLT_NO_FLOW;
                  mode_next = ST_FAULT;
                end else if (lvl_new == LVL_FULL || fill_elapsed >= cfg.max_fill_time_ms) begin
                  mode_next                = ST_COOL;
                  cooldown_start_time_next = item.now_ms;
                end
              end
              ST_COOL: begin
                if (item.flow_detected) begin
                  flt       = 1'b1;
                  flt_code  = FLT_FLOW_OFF;
                  mode_next = ST_FAULT;
                end else if ((item.now_ms - cooldown_start_time) >= cfg.cooldown_ms) begin
                  mode_next = ST_IDLE;
                end
              end
              ST_FAULT: ;
              default: ;
            endcase
            if (lvl_new == LVL_EMPTY) begin
              blk = !item.watering_blocked;
            end else begin
              if (level == LVL_EMPTY) begin
                water_since_next = item.now_ms;
              end
              alw = item.watering_blocked &&
                    ((item.now_ms - water_since_next) >= cfg.allow_watering_delay_ms);
            end
          end
        end
      end
      CMD_START: begin
        if (mode == ST_IDLE && level != LVL_FULL) begin
          mode_next            = ST_FILL;
          fill_start_time_next = item.now_ms;
          acc                  = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (mode == ST_FAULT) begin
          mode_next = ST_IDLE;
          acc       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (mode_next)
      ST_IDLE:  state_code = CTRL_IDLE;
      ST_FILL:  state_code = CTRL_FILL;
      ST_COOL:  state_code = CTRL_COOL;
      ST_FAULT: state_code = CTRL_FAULT;
      default:  state_code = CTRL_IDLE;
    endcase
  end

  always_comb begin
    res.accepted       = acc;
    res.ctrl_state     = state_code;
    res.tank_level     = level_next;
    res.pump_on        = (mode_next == ST_FILL);
    res.fault_raised   = flt;
    res.fault_code     = flt_code;
    res.block_watering = blk;
    res.allow_watering = alw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= ST_IDLE;
      level               <= LVL_UNKNOWN;
      first_pending       <= 1'b1;
      last_update_time    <= '0;
      fill_start_time     <= '0;
      cooldown_start_time <= '0;
      water_since         <= '0;
    end else if (step) begin
      mode                <= mode_next;
      level               <= level_next;
      first_pending       <= first_pending_next;
      last_update_time    <= last_update_time_next;
      fill_start_time     <= fill_start_time_next;
      cooldown_start_time <= cooldown_start_time_next;
      water_since         <= water_since_next;
    end
  end

endmodule

// ----- rtl/tank_fill_pump_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_fill_pump_controller
// Water tank fill controller with level classification, fill/cooldown/fault
// sequencing and watering block/allow requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a command (periodic
//   update, start filling, resume from fault), a millisecond timestamp and
//   the sensor bits. Output channel (out_valid/out_ready) returns exactly one
//   result item per input item, in order.
//   Path: an accepted item enters the input register, then its result
//   enters the result register and out_valid rises. Throughput: one item
//   per cycle while out_ready does not hold the flow; the step logic and
//   the controller state update in the cycle an item moves from the input
//   register to the result register.
//   Stall: while out_ready is low the result register holds its item and the
//   input register takes one more item; in_ready drops once both are full.
//   Reset (rst, synchronous): state returns to idle, level unknown, all
//   timestamps zero, registers to their defaults; the first update after
//   reset runs regardless of its time. Both stages are emptied.
//   Configuration: cfg_we writes cfg_data to register cfg_index at once;
//   write only while no item is in flight.
// ----------------------------------------------------------------------------
module tank_fill_pump_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [31:0]                  now_ms,
  input  logic                         high_level,
  input  logic                         low_level,
  input  logic                         flow_detected,
  input  logic                         watering_blocked,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic [1:0]                   ctrl_state,
  output logic [1:0]                   tank_level,
  output logic                         pump_on,
  output logic                         fault_raised,
  output logic [1:0]                   fault_code,
  output logic                         block_watering,
  output logic                         allow_watering,
  input  logic                         cfg_we,
  input  logic [tfpc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);
  import tfpc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid;
  result_t res_d, res_q;
  logic    step;

  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  tfpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfpc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item_q),
    .cfg  (cfg),
    .res  (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.command          <= command;
      item_q.now_ms           <= now_ms;
      item_q.high_level       <= high_level;
      item_q.low_level        <= low_level;
      item_q.flow_detected    <= flow_detected;
      item_q.watering_blocked <= watering_blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign accepted       = res_q.accepted;
  assign ctrl_state     = res_q.ctrl_state;
  assign tank_level     = res_q.tank_level;
  assign pump_on        = res_q.pump_on;
  assign fault_raised   = res_q.fault_raised;
  assign fault_code     = res_q.fault_code;
  assign block_watering = res_q.block_watering;
  assign allow_watering = res_q.allow_watering;

endmodule
